[rtl/plo_pkg.sv]
// plo_pkg: shared widths, register indexes and light mode codes
// for the pixel light overlay; no dependencies
package plo_pkg;

   localparam int COORD_W    = 16;   // signed coordinate half of a point register
   localparam int PIX_W      = 12;   // pixel index bits
   localparam int FRAC_W     = 8;    // fraction bits of a distance
   localparam int DIF_W      = 18;   // signed coordinate difference
   localparam int PROD_W     = 2 * DIF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int SQ_PAIRS   = 18;
   localparam int SQ_W       = 2 * SQ_PAIRS;
   localparam int ROOT_STEPS = SQ_PAIRS + FRAC_W;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int REM_W      = ROOT_W + 3;
   localparam int CSR_IDX_W  = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_MODE  = 4'd0,
      CSR_LAMP        = 4'd1,
      CSR_APEX_B      = 4'd2,
      CSR_APEX_C      = 4'd3,
      CSR_EDGE_START  = 4'd4,
      CSR_EDGE_END    = 4'd5,
      CSR_STRENGTH    = 4'd6,
      CSR_FALLOFF     = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_RAY   = 2'd0,
      MODE_FLASH = 2'd1,
      MODE_BALL  = 2'd2
   } light_mode_type;

   localparam logic [1:0]  MODE_RESET     = 2'd1;
   localparam logic [7:0]  STRENGTH_RESET = 8'd128;
   localparam logic [15:0] FALLOFF_RESET  = 16'd400;
   localparam logic [7:0]  MAX_V          = 8'd255;

endpackage

[rtl/plo_root_pipe.sv]
// plo_root_pipe: pipelined digit-by-digit square root, one result bit per stage
// depends on plo_pkg
module plo_root_pipe
   import plo_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   sq,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0]   sq_ff   [ROOT_STEPS];
   logic [REM_W-1:0]  rem_ff  [ROOT_STEPS];
   logic [ROOT_W-1:0] root_ff [ROOT_STEPS];

   logic [SQ_W-1:0]   sq_in   [ROOT_STEPS];
   logic [REM_W-1:0]  rem_in  [ROOT_STEPS];
   logic [ROOT_W-1:0] root_in [ROOT_STEPS];

   always_comb begin
      logic [SQ_W-1:0]   s;
      logic [REM_W-1:0]  r;
      logic [ROOT_W-1:0] q;
      logic [REM_W-1:0]  rt;
      logic [REM_W-1:0]  trial;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         if (j == 0) begin
            s = sq;
            r = '0;
            q = '0;
         end else begin
            s = sq_ff[j-1];
            r = rem_ff[j-1];
            q = root_ff[j-1];
         end
         rt    = {r[REM_W-3:0], s[SQ_W-1 -: 2]};
         trial = {{(REM_W-ROOT_W-2){1'b0}}, q, 2'b01};
         sq_in[j] = s << 2;
         if (rt >= trial) begin
            rem_in[j]  = rt - trial;
            root_in[j] = {q[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = rt;
            root_in[j] = {q[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < ROOT_STEPS; j++) begin
            sq_ff[j]   <= sq_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[ROOT_STEPS-1];

endmodule

[rtl/pixel_light_overlay_core.sv]
// pixel_light_overlay_core: adds a distance-faded light to one pixel's brightness
// takes one req word per cycle while req_stall is low; each word passes, in order, through
// 3 front stages, the 26-stage root, multiply, numerator, 9 quotient stages and the output register
// a two-entry output register and skid stage let the pipe run on while rsp is stalled, until the skid fills
// reset clears all valid bits and loads the register defaults (flash mode, radius 400)
// depends on plo_pkg and plo_root_pipe
module pixel_light_overlay_core
   import plo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // pixel words in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_x,
   input  logic [PIX_W-1:0]     req_pixel_y,
   input  logic [7:0]           req_pixel_value,
   // lit words out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_new_value,
   output logic                 rsp_lit,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   // pipeline layout: diffs, products, sums, root steps, multiply, numerator, quotient
   localparam int ST_ROOT  = 3;
   localparam int ST_MUL   = ST_ROOT + ROOT_STEPS;
   localparam int ST_NUM   = ST_MUL + 1;
   localparam int Q_W      = 9;                 // quotient stays below 2 * 256
   localparam int NSTAGE   = ST_NUM + 1 + Q_W;
   localparam int DEN_W    = COORD_W + FRAC_W;
   localparam int MP1_W    = DEN_W + 9;
   localparam int MP2_W    = ROOT_W + 8;
   localparam int NUM_W    = MP2_W + 2;
   localparam int REMD_W   = MP2_W;

   // ---------------- configuration registers ----------------
   logic [1:0]         mode_ff;
   logic [31:0]        lamp_ff, apex_b_ff, apex_c_ff, edge_s_ff, edge_e_ff;
   logic [7:0]         strength_ff;
   logic [COORD_W-1:0] falloff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         lamp_ff     <= '0;
         apex_b_ff   <= '0;
         apex_c_ff   <= '0;
         edge_s_ff   <= '0;
         edge_e_ff   <= '0;
         strength_ff <= STRENGTH_RESET;
         falloff_ff  <= FALLOFF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LIGHT_MODE: mode_ff     <= csr_data[1:0];
            CSR_LAMP:       lamp_ff     <= csr_data;
            CSR_APEX_B:     apex_b_ff   <= csr_data;
            CSR_APEX_C:     apex_c_ff   <= csr_data;
            CSR_EDGE_START: edge_s_ff   <= csr_data;
            CSR_EDGE_END:   edge_e_ff   <= csr_data;
            CSR_STRENGTH:   strength_ff <= csr_data[7:0];
            CSR_FALLOFF:    falloff_ff  <= csr_data[COORD_W-1:0];
            default: ;      // unknown index, write dropped
         endcase
      end
   end

   // packed point halves, sign extended
   function automatic logic signed [DIF_W-1:0] pt_x(input logic [31:0] p);
      return DIF_W'(signed'(p[COORD_W-1:0]));
   endfunction

   function automatic logic signed [DIF_W-1:0] pt_y(input logic [31:0] p);
      return DIF_W'(signed'(p[16 +: COORD_W]));
   endfunction

   logic signed [DIF_W-1:0] lamp_x, lamp_y, b_x, b_y, c_x, c_y;
   logic signed [DIF_W-1:0] e0_x, e0_y, e1_x, e1_y, pix_x, pix_y;
   logic signed [DIF_W-1:0] blx, bly, cbx, cby, lcx, lcy, eex, eey, lex, ley;

   always_comb begin
      lamp_x = pt_x(lamp_ff);   lamp_y = pt_y(lamp_ff);
      b_x    = pt_x(apex_b_ff); b_y    = pt_y(apex_b_ff);
      c_x    = pt_x(apex_c_ff); c_y    = pt_y(apex_c_ff);
      e0_x   = pt_x(edge_s_ff); e0_y   = pt_y(edge_s_ff);
      e1_x   = pt_x(edge_e_ff); e1_y   = pt_y(edge_e_ff);
      pix_x  = signed'(DIF_W'(req_pixel_x));
      pix_y  = signed'(DIF_W'(req_pixel_y));
      // edge vectors that depend on the registers only
      blx = b_x - lamp_x;   bly = b_y - lamp_y;
      cbx = c_x - b_x;      cby = c_y - b_y;
      lcx = lamp_x - c_x;   lcy = lamp_y - c_y;
      eex = e1_x - e0_x;    eey = e1_y - e0_y;
      lex = lamp_x - e0_x;  ley = lamp_y - e0_y;
   end

   // ---------------- flow control ----------------
   // the whole pipe moves together; it holds only while the skid stage is full
   logic              adv;
   logic [NSTAGE-1:0] v_ff;
   logic              out_v_ff, skid_v_ff;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTAGE-2:0], req_valid};
      end
   end

   // ---------------- stage 0: coordinate differences ----------------
   logic signed [DIF_W-1:0] lx_ff, ly_ff, bx_ff, by_ff, cx_ff, cy_ff, ex_ff, ey_ff;
   logic [7:0]              val0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_ff   <= lamp_x - pix_x;
         ly_ff   <= lamp_y - pix_y;
         bx_ff   <= b_x - pix_x;
         by_ff   <= b_y - pix_y;
         cx_ff   <= c_x - pix_x;
         cy_ff   <= c_y - pix_y;
         ex_ff   <= pix_x - e0_x;
         ey_ff   <= pix_y - e0_y;
         val0_ff <= req_pixel_value;
      end
   end

   // ---------------- stage 1: products ----------------
   logic signed [PROD_W-1:0] pr_ff [10];
   logic signed [PROD_W-1:0] sqa0_ff, sqa1_ff, sqb0_ff, sqb1_ff;
   logic [7:0]               val1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // triangle edges lamp->b, b->c, c->lamp
         pr_ff[0] <= PROD_W'(lx_ff) * PROD_W'(bly);
         pr_ff[1] <= PROD_W'(blx) * PROD_W'(ly_ff);
         pr_ff[2] <= PROD_W'(bx_ff) * PROD_W'(cby);
         pr_ff[3] <= PROD_W'(cbx) * PROD_W'(by_ff);
         pr_ff[4] <= PROD_W'(cx_ff) * PROD_W'(lcy);
         pr_ff[5] <= PROD_W'(lcx) * PROD_W'(cy_ff);
         // base edge side of the pixel and of the lamp
         pr_ff[6] <= PROD_W'(ex_ff) * PROD_W'(eey);
         pr_ff[7] <= PROD_W'(ey_ff) * PROD_W'(eex);
         pr_ff[8] <= PROD_W'(lex) * PROD_W'(eey);
         pr_ff[9] <= PROD_W'(ley) * PROD_W'(eex);
         sqa0_ff  <= PROD_W'(lx_ff) * PROD_W'(lx_ff);
         sqa1_ff  <= PROD_W'(ly_ff) * PROD_W'(ly_ff);
         sqb0_ff  <= PROD_W'(bx_ff) * PROD_W'(bx_ff);
         sqb1_ff  <= PROD_W'(by_ff) * PROD_W'(by_ff);
         val1_ff  <= val0_ff;
      end
   end

   // ---------------- stage 2: cross signs and squared distances ----------------
   logic signed [CROSS_W-1:0] d1, d2, d3, dp, dl;
   logic                      in_tri, ray_hit_in;
   logic [SQ_W-1:0]           sqa_ff, sqb_ff;
   logic                      ray2_ff;
   logic [7:0]                val2_ff;

   always_comb begin
      d1 = CROSS_W'(pr_ff[0]) - CROSS_W'(pr_ff[1]);
      d2 = CROSS_W'(pr_ff[2]) - CROSS_W'(pr_ff[3]);
      d3 = CROSS_W'(pr_ff[4]) - CROSS_W'(pr_ff[5]);
      dp = CROSS_W'(pr_ff[6]) - CROSS_W'(pr_ff[7]);
      dl = CROSS_W'(pr_ff[8]) - CROSS_W'(pr_ff[9]);
      // zero products count as inside for either orientation
      in_tri = (!d1[CROSS_W-1] && !d2[CROSS_W-1] && !d3[CROSS_W-1]) ||
               ((d1[CROSS_W-1] || d1 == '0) && (d2[CROSS_W-1] || d2 == '0) &&
                (d3[CROSS_W-1] || d3 == '0));
      ray_hit_in = in_tri || (dl[CROSS_W-1] != dp[CROSS_W-1]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqa_ff  <= SQ_W'(unsigned'(sqa0_ff)) + SQ_W'(unsigned'(sqa1_ff));
         sqb_ff  <= SQ_W'(unsigned'(sqb0_ff)) + SQ_W'(unsigned'(sqb1_ff));
         ray2_ff <= ray_hit_in;
         val2_ff <= val1_ff;
      end
   end

   // ---------------- root stages: distance to lamp and to apex b ----------------
   logic [ROOT_W-1:0] dist_lamp, dist_b;
   logic              rray_ff [ROOT_STEPS];
   logic [7:0]        rval_ff [ROOT_STEPS];

   plo_root_pipe u_root_lamp (
      .clock (clock),
      .en    (adv),
      .sq    (sqa_ff),
      .root  (dist_lamp)
   );

   plo_root_pipe u_root_b (
      .clock (clock),
      .en    (adv),
      .sq    (sqb_ff),
      .root  (dist_b)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rray_ff[0] <= ray2_ff;
         rval_ff[0] <= val2_ff;
         for (int j = 1; j < ROOT_STEPS; j++) begin
            rray_ff[j] <= rray_ff[j-1];
            rval_ff[j] <= rval_ff[j-1];
         end
      end
   end

   // ---------------- multiply stage: hit test and fade products ----------------
   logic [COORD_W-1:0] len_eff;
   logic [DEN_W-1:0]   den;
   logic [ROOT_W-1:0]  lim;
   logic [8:0]         vs_sum;
   logic               hit_in;
   logic               hitm_ff;
   logic [7:0]         valm_ff;
   logic [MP1_W-1:0]   prod1_ff;
   logic [MP2_W-1:0]   prod2_ff;

   always_comb begin
      len_eff = (falloff_ff == '0) ? COORD_W'(1) : falloff_ff;
      den     = {len_eff, FRAC_W'(0)};
      lim     = ROOT_W'(den);
      vs_sum  = 9'(rval_ff[ROOT_STEPS-1]) + 9'(strength_ff);
      case (light_mode_type'(mode_ff))
         MODE_RAY:   hit_in = rray_ff[ROOT_STEPS-1];
         MODE_FLASH: hit_in = (dist_lamp <= lim);
         MODE_BALL:  hit_in = (dist_b <= lim);
         default:    hit_in = 1'b0;   // unused mode lights nothing
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hitm_ff  <= hit_in;
         valm_ff  <= rval_ff[ROOT_STEPS-1];
         prod1_ff <= MP1_W'(vs_sum) * MP1_W'(den);
         prod2_ff <= MP2_W'(strength_ff) * MP2_W'(dist_lamp);
      end
   end

   // ---------------- numerator stage ----------------
   logic [NUM_W-1:0]  num;
   logic              hitn_ff, nonpos_ff;
   logic [7:0]        valn_ff;
   logic [REMD_W-1:0] remn_ff;

   assign num = NUM_W'(prod1_ff) - NUM_W'(prod2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         hitn_ff   <= hitm_ff;
         valn_ff   <= valm_ff;
         nonpos_ff <= num[NUM_W-1] || (num == '0);
         remn_ff   <= REMD_W'(num);
      end
   end

   // ---------------- quotient stages: one bit each, msb first ----------------
   logic [REMD_W-1:0] qrem_in [Q_W];
   logic [Q_W-1:0]    q_in    [Q_W];
   logic [REMD_W-1:0] qrem_ff [Q_W];
   logic [Q_W-1:0]    q_ff    [Q_W];
   logic              qhit_ff [Q_W];
   logic              qneg_ff [Q_W];
   logic [7:0]        qval_ff [Q_W];

   always_comb begin
      logic [REMD_W-1:0] r;
      logic [Q_W-1:0]    q;
      logic [REMD_W-1:0] sh;
      for (int k = 0; k < Q_W; k++) begin
         if (k == 0) begin
            r = remn_ff;
            q = '0;
         end else begin
            r = qrem_ff[k-1];
            q = q_ff[k-1];
         end
         sh = REMD_W'(den) << (Q_W - 1 - k);
         if (r >= sh) begin
            qrem_in[k] = r - sh;
            q_in[k]    = {q[Q_W-2:0], 1'b1};
         end else begin
            qrem_in[k] = r;
            q_in[k]    = {q[Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < Q_W; k++) begin
            qrem_ff[k] <= qrem_in[k];
            q_ff[k]    <= q_in[k];
            if (k == 0) begin
               qhit_ff[k] <= hitn_ff;
               qneg_ff[k] <= nonpos_ff;
               qval_ff[k] <= valn_ff;
            end else begin
               qhit_ff[k] <= qhit_ff[k-1];
               qneg_ff[k] <= qneg_ff[k-1];
               qval_ff[k] <= qval_ff[k-1];
            end
         end
      end
   end

   // ---------------- result, clamp and output/skid registers ----------------
   logic [7:0] res_value;
   logic       res_lit;
   logic [7:0] out_val_ff, skid_val_ff;
   logic       out_lit_ff, skid_lit_ff;
   logic       push, pop;

   always_comb begin
      res_lit = qhit_ff[Q_W-1];
      if (!res_lit)
         res_value = qval_ff[Q_W-1];
      else if (qneg_ff[Q_W-1])
         res_value = '0;
      else if (q_ff[Q_W-1][Q_W-1])
         res_value = MAX_V;
      else
         res_value = q_ff[Q_W-1][7:0];
   end

   assign push = adv && v_ff[NSTAGE-1];
   assign pop  = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_val_ff <= skid_val_ff;
            out_lit_ff <= skid_lit_ff;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_val_ff <= res_value;
            out_lit_ff <= res_lit;
         end else begin
            skid_val_ff <= res_value;
            skid_lit_ff <= res_lit;
         end
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_new_value = out_val_ff;
   assign rsp_lit       = out_lit_ff;

   // ---------------- checks ----------------
   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held without an output word");

   skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid filled while output was free");

   pipe_holds: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(v_ff))
      else $error("pipeline moved while skid was full");

   unlit_keeps_value: assert property (@(posedge clock) disable iff (reset)
      (push && !res_lit) |-> (res_value == qval_ff[Q_W-1]))
      else $error("unlit pixel changed value");

endmodule

[dv/tb_pixel_light_overlay_core.sv]
// tb_pixel_light_overlay_core: self-checking bench for the pixel light overlay core
// drives pixel words, predicts each lit word and compares in order; needs plo_pkg and the rtl
module tb_pixel_light_overlay_core;
   import plo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LATENCY     = 40;
   localparam int          SETTLE      = 2 * LATENCY + 20;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          RAND_PHASES = 8;
   localparam int          PHASE_WORDS = 80;
   localparam int          DIR_ROWS    = 11;
   localparam int          NUM_REGS    = 8;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;      // lights nothing
   localparam logic [3:0]  CSR_UNUSED  = 4'd13;     // no register behind it

   typedef struct packed {
      logic [7:0] new_value;
      logic       lit;
   } lit_word_type;

   typedef struct {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic [7:0]       value;
      bit               typed;
      logic [7:0]       new_value;
      logic             lit;
   } pixel_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_x = '0;
   logic [PIX_W-1:0]     req_pixel_y = '0;
   logic [7:0]           req_pixel_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_new_value;
   logic                 rsp_lit;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   // shadow copy of the register file
   logic [1:0]  shadow_mode;
   logic [31:0] shadow_lamp, shadow_apex_b, shadow_apex_c, shadow_edge_start, shadow_edge_end;
   logic [7:0]  shadow_strength;
   logic [15:0] shadow_falloff;

   lit_word_type lit_queue[$];
   int          errors    = 0;
   int          cycles    = 0;
   int          idle_pct  = 0;   // sender idles this many cycles of a hundred
   int          stall_pct = 0;   // receiver stalls this many cycles of a hundred
   int          hold_left = 0;   // long receiver hold-off, counted down below

   csr_index_type reg_order[NUM_REGS] = '{CSR_LIGHT_MODE, CSR_LAMP, CSR_APEX_B, CSR_APEX_C,
                                          CSR_EDGE_START, CSR_EDGE_END, CSR_STRENGTH,
                                          CSR_FALLOFF};

   // directed pixels; typed results hold for the reset settings only
   // (flash mode, lamp at origin, strength 128, radius 400)
   pixel_row_type dir_rows[DIR_ROWS] = '{
      '{12'd0,    12'd0,    8'd0,   1'b1, 8'd128, 1'b1},  // full boost at the lamp
      '{12'd0,    12'd0,    8'd255, 1'b1, 8'd255, 1'b1},  // sum clamps high
      '{12'd0,    12'd0,    8'd127, 1'b1, 8'd255, 1'b1},  // sum just reaches the top
      '{12'd4095, 12'd4095, 8'd77,  1'b1, 8'd77,  1'b0},  // far corner, untouched
      '{12'd4095, 12'd0,    8'd0,   1'b1, 8'd0,   1'b0},
      '{12'd400,  12'd0,    8'd0,   1'b1, 8'd0,   1'b1},  // exactly on the rim, boost gone
      '{12'd0,    12'd401,  8'd200, 1'b1, 8'd200, 1'b0},  // one past the rim
      '{12'd200,  12'd0,    8'd10,  1'b0, 8'd0,   1'b0},
      '{12'd123,  12'd45,   8'd200, 1'b0, 8'd0,   1'b0},
      '{12'd2730, 12'd1365, 8'd170, 1'b0, 8'd0,   1'b0},
      '{12'd1365, 12'd2730, 8'd85,  1'b0, 8'd0,   1'b0}
   };

   // directed settings, in register index order
   logic [31:0] dir_cfgs[4][NUM_REGS] = '{
      // ray: triangle on the axes, base edge across x + y = 500
      '{32'd0, 32'h0000_0000, 32'h0000_0190, 32'h0190_0000,
        32'h01F4_0000, 32'h0000_01F4, 32'd200, 32'd300},
      // ray with every point coincident: zero products count as inside
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd255, 32'd65535},
      // unused mode lights nothing
      '{32'd3, 32'h0010_0010, 32'd0, 32'd0, 32'd0, 32'd0, 32'd255, 32'd50},
      // ball with zero falloff taken as one, lamp at the most negative corner
      '{32'd2, 32'h8000_8000, 32'h0555_0AAA, 32'hFFFF_FFFF,
        32'h7FFF_7FFF, 32'h8000_0001, 32'd255, 32'd0}
   };

   pixel_light_overlay_core i_dut (.*);

   always #2ns clock = ~clock;

   // ---------------- predictor ----------------

   function automatic longint coord(input logic [15:0] half);
      return longint'($signed(half));
   endfunction

   // distance scaled by 2^FRAC_W, floored, digit by digit
   function automatic longint unsigned scaled_root(input longint unsigned sq);
      longint unsigned rem, root, trial, pair;
      rem  = 0;
      root = 0;
      for (int i = 0; i < ROOT_STEPS; i++) begin
         pair = (i < SQ_PAIRS) ? ((sq >> (2 * (SQ_PAIRS - 1 - i))) & 3) : 0;
         rem  = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint unsigned light_distance(input longint ax, input longint ay,
                                                      input longint bx, input longint by);
      longint dx, dy;
      dx = bx - ax;
      dy = by - ay;
      return scaled_root(longint'(dx * dx + dy * dy));
   endfunction

   function automatic longint edge_cross(input longint ax, input longint ay, input longint bx,
                                         input longint by, input longint px, input longint py);
      return (ax - px) * (by - ay) - (bx - ax) * (ay - py);
   endfunction

   function automatic logic [7:0] fade_brightness(input logic [7:0] v, input longint len,
                                                  input longint unsigned dist_fx);
      longint den, num, q;
      den = len << FRAC_W;
      num = (longint'(v) + longint'(shadow_strength)) * den
            - longint'(shadow_strength) * longint'(dist_fx);
      if (num <= 0) return 8'd0;
      q = num / den;
      return (q > 255) ? MAX_V : q[7:0];
   endfunction

   function automatic lit_word_type light_pixel(input logic [PIX_W-1:0] x,
                                                input logic [PIX_W-1:0] y,
                                                input logic [7:0] v);
      longint    px, py, lx, ly, bx, by, cx, cy, e0x, e0y, e1x, e1y, len, d1, d2, d3, ds_l, ds_p;
      bit        in_tri;
      lit_word_type w;
      px  = longint'(x);
      py  = longint'(y);
      lx  = coord(shadow_lamp[15:0]);       ly  = coord(shadow_lamp[31:16]);
      bx  = coord(shadow_apex_b[15:0]);     by  = coord(shadow_apex_b[31:16]);
      cx  = coord(shadow_apex_c[15:0]);     cy  = coord(shadow_apex_c[31:16]);
      e0x = coord(shadow_edge_start[15:0]); e0y = coord(shadow_edge_start[31:16]);
      e1x = coord(shadow_edge_end[15:0]);   e1y = coord(shadow_edge_end[31:16]);
      len = (shadow_falloff == 0) ? 1 : longint'(shadow_falloff);
      w.new_value = v;
      w.lit       = 1'b0;
      case (shadow_mode)
         MODE_RAY: begin
            d1 = edge_cross(lx, ly, bx, by, px, py);
            d2 = edge_cross(bx, by, cx, cy, px, py);
            d3 = edge_cross(cx, cy, lx, ly, px, py);
            in_tri = (d1 >= 0 && d2 >= 0 && d3 >= 0) || (d1 <= 0 && d2 <= 0 && d3 <= 0);
            // side of the base edge for lamp and pixel
            ds_l = (lx - e0x) * (e1y - e0y) - (ly - e0y) * (e1x - e0x);
            ds_p = (px - e0x) * (e1y - e0y) - (py - e0y) * (e1x - e0x);
            w.lit = in_tri || ((ds_l >= 0) != (ds_p >= 0));
         end
         MODE_FLASH: w.lit = light_distance(lx, ly, px, py) <= longint'(len << FRAC_W);
         MODE_BALL:  w.lit = light_distance(bx, by, px, py) <= longint'(len << FRAC_W);
         default:    w.lit = 1'b0;
      endcase
      if (w.lit) w.new_value = fade_brightness(v, len, light_distance(lx, ly, px, py));
      return w;
   endfunction

   function automatic void shadow_write(input logic [3:0] idx, input logic [31:0] data);
      case (idx)
         CSR_LIGHT_MODE: shadow_mode       = data[1:0];
         CSR_LAMP:       shadow_lamp       = data;
         CSR_APEX_B:     shadow_apex_b     = data;
         CSR_APEX_C:     shadow_apex_c     = data;
         CSR_EDGE_START: shadow_edge_start = data;
         CSR_EDGE_END:   shadow_edge_end   = data;
         CSR_STRENGTH:   shadow_strength   = data[7:0];
         CSR_FALLOFF:    shadow_falloff    = data[15:0];
         default: ;      // unknown index, ignored
      endcase
   endfunction

   // ---------------- drivers ----------------

   // called at a falling edge, returns at a falling edge with csr_valid still high
   task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, data);
      @(negedge clock);
   endtask

   task automatic write_all_regs(input logic [31:0] vals[NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) write_reg(reg_order[i], vals[i]);
      csr_valid <= 1'b0;
   endtask

   // one pixel word; starts and ends at a falling edge, valid left high
   task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                             input logic [7:0] v, input bit typed,
                             input lit_word_type typed_word);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      req_pixel_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lit_queue.insert(lit_queue.size(), typed ? typed_word : light_pixel(x, y, v));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (lit_queue.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic walk_rows(input int first, input bit use_typed);
      for (int r = first; r < DIR_ROWS; r++)
         send_pixel(dir_rows[r].x, dir_rows[r].y, dir_rows[r].value,
                    use_typed && dir_rows[r].typed, '{dir_rows[r].new_value, dir_rows[r].lit});
   endtask

   function automatic logic [31:0] rand_point;
      logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      case ($urandom_range(3))
         0: return $urandom;
         1: return {4'd0, 12'($urandom), 4'd0, 12'($urandom)};
         2: return {16'($urandom_range(5100) - 500), 16'($urandom_range(5100) - 500)};
         default: return {ext[$urandom_range(3)], ext[$urandom_range(3)]};
      endcase
   endfunction

   task automatic random_settings;
      logic [31:0] vals[NUM_REGS];
      vals[CSR_LIGHT_MODE] = ($urandom_range(9) == 0) ? MODE_UNUSED : $urandom_range(2);
      vals[CSR_LAMP]       = rand_point();
      vals[CSR_APEX_B]     = rand_point();
      vals[CSR_APEX_C]     = rand_point();
      vals[CSR_EDGE_START] = rand_point();
      vals[CSR_EDGE_END]   = rand_point();
      case ($urandom_range(3))
         0:       vals[CSR_STRENGTH] = 255;
         1:       vals[CSR_STRENGTH] = 0;
         default: vals[CSR_STRENGTH] = $urandom;   // upper bits dropped by the block
      endcase
      case ($urandom_range(4))
         0:       vals[CSR_FALLOFF] = 65535;
         1:       vals[CSR_FALLOFF] = $urandom_range(1);
         default: vals[CSR_FALLOFF] = $urandom_range(3000, 1);
      endcase
      write_all_regs(vals);
   endtask

   // half the pixels land near the lamp or the ball centre so the rim gets hit
   task automatic random_pixels(input int count);
      logic [31:0]      ctr;
      int               reach;
      logic [PIX_W-1:0] x, y;
      logic [7:0]       v;
      for (int n = 0; n < count; n++) begin
         x = $urandom;
         y = $urandom;
         if ($urandom_range(1)) begin
            ctr   = (shadow_mode == MODE_BALL) ? shadow_apex_b : shadow_lamp;
            reach = (shadow_falloff > 1000) ? 1000 : shadow_falloff + 2;
            x = PIX_W'(ctr[15:0]  + $urandom_range(2 * reach) - reach);
            y = PIX_W'(ctr[31:16] + $urandom_range(2 * reach) - reach);
         end
         v = ($urandom_range(7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
         send_pixel(x, y, v, 1'b0, '0);
      end
   endtask

   // ---------------- receiver and checker ----------------

   // rsp_stall gets exactly one update per falling edge
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      lit_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lit_queue.size() == 0) begin
            $display("%0t: lit word with nothing expected: new_value %0d lit %0b",
                     $time, rsp_new_value, rsp_lit);
            errors++;
         end else begin
            want = lit_queue.pop_front();
            if (rsp_new_value !== want.new_value) begin
               $display("%0t: new_value expected %0d actual %0d",
                        $time, want.new_value, rsp_new_value);
               errors++;
            end
            if (rsp_lit !== want.lit) begin
               $display("%0t: lit expected %0b actual %0b", $time, want.lit, rsp_lit);
               errors++;
            end
         end
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** pixel_light_overlay_core: FAILED **");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      shadow_write(CSR_LIGHT_MODE, 32'(MODE_RESET));
      shadow_write(CSR_LAMP,       32'd0);
      shadow_write(CSR_APEX_B,     32'd0);
      shadow_write(CSR_APEX_C,     32'd0);
      shadow_write(CSR_EDGE_START, 32'd0);
      shadow_write(CSR_EDGE_END,   32'd0);
      shadow_write(CSR_STRENGTH,   32'(STRENGTH_RESET));
      shadow_write(CSR_FALLOFF,    32'(FALLOFF_RESET));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, typed results where a row has them
      walk_rows(0, 1'b1);
      drain();

      // directed settings, a few pixels each
      for (int c = 0; c < 4; c++) begin
         write_all_regs(dir_cfgs[c]);
         walk_rows(DIR_ROWS - 3, 1'b0);
         drain();
      end

      // a write to a missing register, dropped by the block and the shadow alike
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      @(negedge clock);

      // random settings under each idling pattern, including a stretch with none
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         random_settings();
         random_pixels(PHASE_WORDS);
         drain();
      end

      // long receiver hold-off while pixels keep coming, so the pipe backs up
      idle_pct  = 0;
      stall_pct = 0;
      random_settings();
      hold_left = 300;
      random_pixels(120);
      drain();

      if (errors == 0)
         $display("** pixel_light_overlay_core: PASSED **");
      else
         $display("** pixel_light_overlay_core: FAILED **");
      $finish;
   end

endmodule

[sim.f]
rtl/plo_pkg.sv
rtl/plo_root_pipe.sv
rtl/pixel_light_overlay_core.sv
dv/tb_pixel_light_overlay_core.sv
